// ----- rtl/core/alu16fm_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// alu16fm_pkg: shared definitions of the 16-bit flag ALU
// Opcodes, flag bit positions, step counts of the iterative multiply/divide
// unit and the command/status structs that connect it to the sequencer.
// ----------------------------------------------------------------------------
package alu16fm_pkg;

  localparam logic [2:0] OP_ADD16 = 3'd0;
  localparam logic [2:0] OP_ADD32 = 3'd1;
  localparam logic [2:0] OP_MUL   = 3'd2;
  localparam logic [2:0] OP_DIV   = 3'd3;
  localparam logic [2:0] OP_CMP   = 3'd4;
  localparam logic [2:0] OP_NEG   = 3'd5;

  localparam int FLAG_W = 7;
  localparam int FLAG_Z = 0;
  localparam int FLAG_M = 1;
  localparam int FLAG_C = 2;
  localparam int FLAG_V = 3;
  localparam int FLAG_E = 4;
  localparam int FLAG_G = 5;
  localparam int FLAG_L = 6;

  localparam int DIV_STEPS = 32;
  localparam int MUL_STEPS = 16;
  localparam int CNT_W     = $clog2(DIV_STEPS + 1);

  typedef struct packed {
    logic        start;
    logic        is_div;
    logic [15:0] opnd;   // multiplicand magnitude or divisor magnitude
    logic [31:0] work;   // dividend magnitude, or multiplier magnitude in the low half
  } md_cmd_t;

  typedef struct packed {
    logic        busy;
    logic [15:0] rem;    // remainder, or high product half
    logic [31:0] work;   // quotient, or low product half in the low half
  } md_stat_t;

  function automatic logic [15:0] mag16(input logic [15:0] v);
    return v[15] ? 16'(~v + 16'd1) : v;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/alu16fm_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// alu16fm interfaces: input and result channels
// Valid/ready channels that carry one ALU request and one ALU result.
// ----------------------------------------------------------------------------
interface alu16fm_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         opcode;
  logic [2:0]         reg_first;
  logic [2:0]         reg_second;
  logic [15:0]        first_value;
  logic [15:0]        second_value;
  logic [15:0]        arg_hi;
  logic [15:0]        arg_lo;
  logic               carry_in;
  logic               subtract;
  logic signed [31:0] cmp_a;
  logic signed [31:0] cmp_b;

  modport source (output valid, opcode, reg_first, reg_second, first_value, second_value,
                  arg_hi, arg_lo, carry_in, subtract, cmp_a, cmp_b, input ready);
  modport sink   (input valid, opcode, reg_first, reg_second, first_value, second_value,
                  arg_hi, arg_lo, carry_in, subtract, cmp_a, cmp_b, output ready);
endinterface

interface alu16fm_out_if;
  logic        valid;
  logic        ready;
  logic        write_first;
  logic [2:0]  first_index;
  logic [15:0] first_data;
  logic        write_second;
  logic [2:0]  second_index;
  logic [15:0] second_data;
  logic [6:0]  flags;
  logic        div_zero_int;
  logic        div_overflow_int;

  modport source (output valid, write_first, first_index, first_data, write_second,
                  second_index, second_data, flags, div_zero_int, div_overflow_int,
                  input ready);
  modport sink   (input valid, write_first, first_index, first_data, write_second,
                  second_index, second_data, flags, div_zero_int, div_overflow_int,
                  output ready);
endinterface
`default_nettype wire

// ----- rtl/core/alu16_flags_muldiv_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// alu16_flags_muldiv_unit: 16-bit ALU with status flags, multiply and divide
// Sequencer, flag register and result register around the iterative unit.
// ----------------------------------------------------------------------------
// The unit takes one request at a time and returns exactly one result per
// request. The input is ready only while the sequencer is idle. An add16,
// add32, compare, negate or unused opcode passes through a setup state and
// a finish state only. A multiply runs 16 shift-add steps on the shared
// 17-bit adder; a divide runs 32 restoring steps on the same adder. The
// iteration count of that adder sets how long a request holds the unit,
// and no new request is taken until the previous one leaves the finish state.
// A divide by zero skips the iteration. The result sits in an output
// register, and the unit goes back to idle as soon as the result is loaded,
// so a new request may be taken while the previous result waits for its
// transfer. The flag register (Z, M, C, V, E, G, L) is updated in the same
// cycle the result register is loaded, and each result carries the flags
// as they are after its own operation.
// ----------------------------------------------------------------------------
module alu16_flags_muldiv_unit (
  input wire             clk,
  input wire             rst_n,
  alu16fm_in_if.sink     in_ch,
  alu16fm_out_if.source  out_ch
);
  import alu16fm_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_EXEC, ST_WAIT, ST_FIN} state_t;

  state_t state_r;

  // Captured request.
  logic [2:0]  op_r, r1_r, r2_r;
  logic [15:0] v1_r, v2_r, ahi_r, alo_r;
  logic        cin_r, sub_r;
  logic [31:0] ca_r, cb_r;
  logic [31:0] b32_r;   // add32 argument after optional negation

  logic [FLAG_W-1:0] flag_r;

  // Result register.
  logic              out_valid_r;
  logic              w1_r, w2_r, dz_r, dov_r;
  logic [2:0]        i1_r, i2_r;
  logic [15:0]       d1_r, d2_r;
  logic [FLAG_W-1:0] oflags_r;

  md_cmd_t  cmd;
  md_stat_t stat;

  logic in_xfer, out_xfer, load_out;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign out_xfer    = out_valid_r && out_ch.ready;
  assign load_out    = (state_r == ST_FIN) && (!out_valid_r || out_ch.ready);

  // Operand setup for the iterative unit.
  logic [31:0] dividend;
  always_comb begin
    dividend   = {v1_r, v2_r};
    cmd.start  = (state_r == ST_EXEC) &&
                 ((op_r == OP_MUL) || ((op_r == OP_DIV) && (alo_r != 16'd0)));
    cmd.is_div = (op_r == OP_DIV);
    if (op_r == OP_DIV) begin
      cmd.opnd = mag16(alo_r);
      cmd.work = dividend[31] ? 32'(~dividend + 32'd1) : dividend;
    end else begin
      cmd.opnd = mag16(v2_r);
      cmd.work = {16'd0, mag16(alo_r)};
    end
  end

  alu16fm_muldiv u_muldiv (
    .clk  (clk),
    .rst_n(rst_n),
    .cmd  (cmd),
    .stat (stat)
  );

  // Result computation in the finish cycle.
  logic [16:0]       s16, sn;
  logic [32:0]       s33;
  logic [31:0]       pm, p, q;
  logic [15:0]       r16;
  logic              w1, w2, dz, dov;
  logic [15:0]       d1, d2;
  logic [FLAG_W-1:0] flags_nxt;

  always_comb begin
    s16 = {1'b0, v1_r} + {1'b0, alo_r} + 17'(cin_r);
    sn  = {1'b0, ~v1_r} + 17'(cin_r);
    s33 = {1'b0, v1_r, v2_r} + {1'b0, b32_r};
    pm  = {stat.rem, stat.work[15:0]};
    p   = (v2_r[15] ^ alo_r[15]) ? 32'(~pm + 32'd1) : pm;
    q   = (v1_r[15] ^ alo_r[15]) ? 32'(~stat.work + 32'd1) : stat.work;
    r16 = v1_r[15] ? 16'(~stat.rem + 16'd1) : stat.rem;

    w1        = 1'b0;
    w2        = 1'b0;
    d1        = '0;
    d2        = '0;
    dz        = 1'b0;
    dov       = 1'b0;
    flags_nxt = flag_r;
    case (op_r)
      OP_ADD16: begin
        w1                = 1'b1;
        d1                = s16[15:0];
        flags_nxt[FLAG_Z] = (s16[15:0] == 16'd0);
        flags_nxt[FLAG_M] = s16[15];
        flags_nxt[FLAG_C] = s16[16];
        flags_nxt[FLAG_V] = (v1_r[15] == alo_r[15]) && (s16[15] != v1_r[15]);
      end
      OP_ADD32: begin
        w1                = (r1_r != r2_r);
        w2                = 1'b1;
        d1                = s33[31:16];
        d2                = s33[15:0];
        flags_nxt[FLAG_Z] = (s33[31:0] == 32'd0);
        flags_nxt[FLAG_M] = s33[31];
        flags_nxt[FLAG_C] = s33[32];
        flags_nxt[FLAG_V] = (v1_r[15] == b32_r[31]) && (s33[31] != v1_r[15]);
      end
      OP_MUL: begin
        w1                = (r1_r != r2_r);
        w2                = 1'b1;
        d1                = p[31:16];
        d2                = p[15:0];
        flags_nxt[FLAG_Z] = (p == 32'd0);
        flags_nxt[FLAG_M] = p[31];
        flags_nxt[FLAG_V] = 1'b0;
      end
      OP_DIV: begin
        if (alo_r == 16'd0) begin
          dz = 1'b1;
        end else begin
          w1                = 1'b1;
          w2                = (r1_r != r2_r);
          d1                = r16;
          d2                = q[15:0];
          // The quotient fits in 16 signed bits only if bits 31..15 agree.
          dov               = !((q[31:15] == '0) || (q[31:15] == '1));
          flags_nxt[FLAG_Z] = (q == 32'd0);
          flags_nxt[FLAG_M] = q[31];
        end
      end
      OP_CMP: begin
        flags_nxt[FLAG_E] = (ca_r == cb_r);
        flags_nxt[FLAG_G] = ($signed(ca_r) > $signed(cb_r));
        flags_nxt[FLAG_L] = ($signed(ca_r) < $signed(cb_r));
      end
      OP_NEG: begin
        w1                = 1'b1;
        d1                = sn[15:0];
        flags_nxt[FLAG_Z] = (sn[15:0] == 16'd0);
        flags_nxt[FLAG_M] = sn[15];
        flags_nxt[FLAG_C] = sn[16];
        flags_nxt[FLAG_V] = (sn[15] != v1_r[15]);
      end
      default: begin
        // Unused opcodes write nothing and keep the flags.
      end
    endcase
  end

  // Sequencer, flag register and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      flag_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // A new result takes the register in the same cycle the old one leaves.
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_xfer) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_xfer) begin
            state_r <= ST_EXEC;
            op_r    <= in_ch.opcode;
            r1_r    <= in_ch.reg_first;
            r2_r    <= in_ch.reg_second;
            v1_r    <= in_ch.first_value;
            v2_r    <= in_ch.second_value;
            ahi_r   <= in_ch.arg_hi;
            alo_r   <= in_ch.arg_lo;
            cin_r   <= in_ch.carry_in;
            sub_r   <= in_ch.subtract;
            ca_r    <= in_ch.cmp_a;
            cb_r    <= in_ch.cmp_b;
          end
        end
        ST_EXEC: begin
          b32_r   <= sub_r ? 32'(~{ahi_r, alo_r} + 32'd1) : {ahi_r, alo_r};
          state_r <= cmd.start ? ST_WAIT : ST_FIN;
        end
        ST_WAIT: begin
          if (!stat.busy) begin
            state_r <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (load_out) begin
            state_r     <= ST_IDLE;
            flag_r      <= flags_nxt;
            w1_r        <= w1;
            i1_r        <= w1 ? r1_r : 3'd0;
            d1_r        <= w1 ? d1 : 16'd0;
            w2_r        <= w2;
            i2_r        <= w2 ? r2_r : 3'd0;
            d2_r        <= w2 ? d2 : 16'd0;
            oflags_r    <= flags_nxt;
            dz_r        <= dz;
            dov_r       <= dov;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.write_first      = w1_r;
  assign out_ch.first_index      = i1_r;
  assign out_ch.first_data       = d1_r;
  assign out_ch.write_second     = w2_r;
  assign out_ch.second_index     = i2_r;
  assign out_ch.second_data      = d2_r;
  assign out_ch.flags            = oflags_r;
  assign out_ch.div_zero_int     = dz_r;
  assign out_ch.div_overflow_int = dov_r;

  // A divide by zero never carries a register write-back.
  a_dz_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && dz_r |-> !w1_r && !w2_r)
    else $error("divide by zero result carries a write-back");

  // The iterative unit only runs while the sequencer waits for it.
  a_busy_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    stat.busy |-> state_r == ST_WAIT)
    else $error("multiply/divide unit busy outside the wait state");

  // Flags change only when a result is loaded.
  a_flags_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !load_out |=> $stable(flag_r))
    else $error("flag register changed without a result load");

  // A request transfer always takes the sequencer out of idle.
  a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> state_r == ST_EXEC)
    else $error("sequencer did not start after a request transfer");

endmodule
`default_nettype wire

// ----- rtl/core/alu16fm_muldiv.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// alu16fm_muldiv: iterative unsigned multiply / divide unit
// One shared 17-bit adder/subtractor runs shift-add multiply (16 steps) or
// restoring division (32 steps), one step per cycle.
// ----------------------------------------------------------------------------
module alu16fm_muldiv (
  input  wire                    clk,
  input  wire                    rst_n,
  input  alu16fm_pkg::md_cmd_t   cmd,
  output alu16fm_pkg::md_stat_t  stat
);
  import alu16fm_pkg::*;

  logic             busy_r;
  logic             is_div_r;
  logic [CNT_W-1:0] cnt_r;
  logic [15:0]      opnd_r;
  logic [15:0]      rem_r, rem_nxt;
  logic [31:0]      work_r, work_nxt;

  logic [16:0] sh;
  logic [16:0] add_a, add_b;
  logic [17:0] add_res;
  logic [16:0] mul_sum;

  always_comb begin
    sh      = {rem_r, work_r[31]};
    add_a   = is_div_r ? sh : {1'b0, rem_r};
    add_b   = {1'b0, opnd_r};
    // Subtract in division: a carry into bit 17 means no borrow.
    add_res = {1'b0, add_a} + {1'b0, (is_div_r ? ~add_b : add_b)} + 18'(is_div_r);
    mul_sum = work_r[0] ? add_res[16:0] : {1'b0, rem_r};
    if (is_div_r) begin
      rem_nxt  = add_res[17] ? add_res[15:0] : sh[15:0];
      work_nxt = {work_r[30:0], add_res[17]};
    end else begin
      rem_nxt  = mul_sum[16:1];
      work_nxt = {work_r[31:16], mul_sum[0], work_r[15:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (cmd.start) begin
      busy_r <= 1'b1;
      cnt_r  <= cmd.is_div ? CNT_W'(DIV_STEPS) : CNT_W'(MUL_STEPS);
    end else if (busy_r) begin
      cnt_r <= cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      is_div_r <= cmd.is_div;
      opnd_r   <= cmd.opnd;
      work_r   <= cmd.work;
      rem_r    <= '0;
    end else if (busy_r) begin
      rem_r  <= rem_nxt;
      work_r <= work_nxt;
    end
  end

  assign stat.busy = busy_r;
  assign stat.rem  = rem_r;
  assign stat.work = work_r;

endmodule
`default_nettype wire
